// ===== design/ebr_pkg.sv =====
// Shared types, constants and the quadrature direction function for the
// encoder/button report block. No dependencies.
package ebr_pkg;

   localparam int CMD_W        = 3;
   localparam int AB_W         = 2;
   localparam int BTN_W        = 3;
   localparam int BYTE_W       = 8;
   localparam int DEBOUNCE_W   = 10;
   localparam int IDLE_W       = 11;
   localparam int BUTTONS_DEF  = 5;
   localparam int REPORT_BYTES = 12;
   localparam int INDEX_W      = $clog2(REPORT_BYTES + 1);

   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = DEBOUNCE_W'(100);
   localparam logic [IDLE_W-1:0]     IDLE_MAX       = {IDLE_W{1'b1}};
   localparam logic [BYTE_W-1:0]     PAST_END_BYTE  = 8'hFF;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK   = 3'd0,
      CMD_SAMPLE = 3'd1,
      CMD_PRESS  = 3'd2,
      CMD_HOLD   = 3'd3,
      CMD_MATCH  = 3'd4,
      CMD_READ   = 3'd5
   } ebr_command_type;

   // One decoded event, valid for the cycle in which the item is processed.
   typedef struct packed {
      logic              tick;
      logic              sample;
      logic              press;
      logic              hold;
      logic              match;
      logic              read;
      logic              error;
      logic [AB_W-1:0]   ab;
      logic [BTN_W-1:0]  button;
      logic [BYTE_W-1:0] error_bits;
   } ebr_event_type;

   // Gray step: +1 forward, -1 backward, 0 for no change or a double jump.
   function automatic logic signed [1:0] gray_dir(input logic [AB_W-1:0] from,
                                                  input logic [AB_W-1:0] to);
      logic signed [1:0] dir;
      begin
         case ({from, to})
            4'b0001, 4'b0111, 4'b1000, 4'b1110: dir = 2'sd1;
            4'b0010, 4'b0100, 4'b1011, 4'b1101: dir = -2'sd1;
            default:                            dir = 2'sd0;
         endcase
         return dir;
      end
   endfunction

endpackage

// ===== design/ebr_encoder.sv =====
// Quadrature decoder: phase, saturating step count, idle tick counter and
// the debounce register. Depends on ebr_pkg.
module ebr_encoder (
   input  logic                           clock,
   input  logic                           reset,
   input  ebr_pkg::ebr_event_type         ev,
   input  logic                           snap_take,
   input  logic                           csr_write_enable,
   input  logic [ebr_pkg::DEBOUNCE_W-1:0] csr_write_data,
   output logic [ebr_pkg::BYTE_W-1:0]     whole_steps
);
   import ebr_pkg::*;

   logic [AB_W-1:0]        phase_ff, phase_in;
   logic signed [7:0]      step_ff, step_in;
   logic [IDLE_W-1:0]      idle_ff, idle_in;
   logic [DEBOUNCE_W-1:0]  debounce_ff, debounce_in;

   logic signed [7:0]      base;
   logic signed [8:0]      sum;
   logic signed [7:0]      whole;
   logic signed [7:0]      remainder;

   // Division by 4 rounding toward zero; remainder keeps the sign.
   always_comb begin
      whole     = step_ff >>> 2;
      if (step_ff[7] && (step_ff[1:0] != 2'b00)) begin
         whole = whole + 8'sd1;
      end
      remainder = step_ff - (whole <<< 2);
   end

   assign whole_steps = whole;

   always_comb begin
      base = step_ff;
      if ((idle_ff > {1'b0, debounce_ff}) && (step_ff > -8'sd4) && (step_ff < 8'sd4)) begin
         base = 8'sd0;
      end
      sum = 9'(base) + 9'(gray_dir(phase_ff, ev.ab));
   end

   always_comb begin
      phase_in    = phase_ff;
      step_in     = step_ff;
      idle_in     = idle_ff;
      debounce_in = csr_write_enable ? csr_write_data : debounce_ff;
      if (ev.tick && (idle_ff < IDLE_MAX)) begin
         idle_in = idle_ff + IDLE_W'(1);
      end
      if (ev.sample) begin
         phase_in = ev.ab;
         idle_in  = '0;
         if (sum > 9'sd127) begin
            step_in = 8'sd127;
         end else if (sum < -9'sd128) begin
            step_in = -8'sd128;
         end else begin
            step_in = sum[7:0];
         end
      end
      if (snap_take) begin
         step_in = remainder;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= '0;
         step_ff     <= '0;
         idle_ff     <= '0;
         debounce_ff <= DEBOUNCE_RESET;
      end else begin
         phase_ff    <= phase_in;
         step_ff     <= step_in;
         idle_ff     <= idle_in;
         debounce_ff <= debounce_in;
      end
   end

endmodule

// ===== design/ebr_report.sv =====
// Button counters, bus status, report snapshot and read index; produces the
// byte for a read event. Depends on ebr_pkg.
module ebr_report #(
   parameter int BUTTONS = ebr_pkg::BUTTONS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ebr_pkg::ebr_event_type     ev,
   input  logic [ebr_pkg::BYTE_W-1:0] whole_steps,
   output logic                       snap_take,
   output logic [ebr_pkg::BYTE_W-1:0] read_byte
);
   import ebr_pkg::*;

   logic [BYTE_W-1:0]  press_ff [BUTTONS];
   logic [BYTE_W-1:0]  press_in [BUTTONS];
   logic [BYTE_W-1:0]  hold_ff  [BUTTONS];
   logic [BYTE_W-1:0]  hold_in  [BUTTONS];
   logic [BYTE_W-1:0]  snap_ff  [REPORT_BYTES];
   logic [BYTE_W-1:0]  snap_in  [REPORT_BYTES];
   logic [BYTE_W-1:0]  status_ff, status_in;
   logic [INDEX_W-1:0] index_ff, index_in;

   assign snap_take = ev.read && (index_ff == '0);

   // Byte 0 is always the live status at snapshot time.
   always_comb begin
      if (snap_take) begin
         read_byte = status_ff;
      end else if (index_ff < INDEX_W'(REPORT_BYTES)) begin
         read_byte = snap_ff[index_ff[$clog2(REPORT_BYTES)-1:0]];
      end else begin
         read_byte = PAST_END_BYTE;
      end
   end

   always_comb begin
      status_in = ev.error ? (status_ff | ev.error_bits) : status_ff;
      index_in  = index_ff;
      if (ev.error || ev.match) begin
         index_in = '0;
      end else if (ev.read && (index_ff < INDEX_W'(REPORT_BYTES))) begin
         index_in = index_ff + INDEX_W'(1);
      end
   end

   always_comb begin
      for (int i = 0; i < BUTTONS; i++) begin
         press_in[i] = press_ff[i];
         hold_in[i]  = hold_ff[i];
         if (snap_take) begin
            press_in[i] = '0;
            hold_in[i]  = '0;
         end else begin
            if (ev.press && (ev.button == BTN_W'(i))) begin
               press_in[i] = press_ff[i] + BYTE_W'(1);
            end
            if (ev.hold && (ev.button == BTN_W'(i))) begin
               hold_in[i] = hold_ff[i] + BYTE_W'(1);
            end
         end
      end
   end

   // Snapshot layout: status, whole steps, press counters, hold counters.
   always_comb begin
      for (int k = 0; k < REPORT_BYTES; k++) begin
         snap_in[k] = snap_ff[k];
         if (snap_take) begin
            if (k == 0) begin
               snap_in[k] = status_ff;
            end else if (k == 1) begin
               snap_in[k] = whole_steps;
            end else if (k - 2 < BUTTONS) begin
               snap_in[k] = press_ff[k-2];
            end else if (k - 2 - BUTTONS < BUTTONS) begin
               snap_in[k] = hold_ff[k-2-BUTTONS];
            end else begin
               snap_in[k] = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= '0;
         index_ff  <= '0;
         for (int i = 0; i < BUTTONS; i++) begin
            press_ff[i] <= '0;
            hold_ff[i]  <= '0;
         end
      end else begin
         status_ff <= status_in;
         index_ff  <= index_in;
         for (int i = 0; i < BUTTONS; i++) begin
            press_ff[i] <= press_in[i];
            hold_ff[i]  <= hold_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < REPORT_BYTES; k++) begin
         snap_ff[k] <= snap_in[k];
      end
   end

endmodule

// ===== design/encoder_button_i2c_report.sv =====
// Top level of the encoder/button report block: input register, event
// decode and result register. Depends on ebr_pkg, ebr_encoder, ebr_report.
//
// Usage:
//  - req_* carries one event per item: tick, encoder sample, press, hold,
//    address match or read byte; req_bus_error set makes it a bus error.
//  - rsp_* returns one item for each read byte event and nothing for the
//    other events. rsp_read_valid is always 1 on a returned item.
//  - csr_write_enable/csr_write_data set debounce_ms; write only when idle.
// Timing:
//  - An accepted item sits in the input register and is processed there;
//    a read's byte is then loaded into the result register, which drives
//    rsp_valid.
//  - One item per cycle sustained while no read waits on a held result; every
//    event is a single register update on the input-to-result path.
// Stall:
//  - When rsp_ready is low and a result is held, a further read event waits
//    in the input register; req_ready drops only then. Non-read events keep
//    flowing past a held result.
// Reset:
//  - Synchronous, active high. Clears counters, status, read index and the
//    channel valids; debounce_ms returns to 100.
module encoder_button_i2c_report #(
   parameter int BUTTONS = ebr_pkg::BUTTONS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [ebr_pkg::CMD_W-1:0]      req_command,
   input  logic [ebr_pkg::AB_W-1:0]       req_encoder_ab,
   input  logic [ebr_pkg::BTN_W-1:0]      req_button_index,
   input  logic                           req_bus_error,
   input  logic [ebr_pkg::BYTE_W-1:0]     req_error_bits,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [ebr_pkg::BYTE_W-1:0]     rsp_read_data,
   output logic                           rsp_read_valid,
   input  logic                           csr_write_enable,
   input  logic [ebr_pkg::DEBOUNCE_W-1:0] csr_write_data
);
   import ebr_pkg::*;

   // Input register
   logic               in_valid_ff, in_valid_in;
   logic [CMD_W-1:0]   cmd_ff;
   logic [AB_W-1:0]    ab_ff;
   logic [BTN_W-1:0]   btn_ff;
   logic               err_ff;
   logic [BYTE_W-1:0]  ebits_ff;

   // Result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]  rsp_data_ff;

   logic               produces;
   logic               advance;
   logic               snap_take;
   logic [BYTE_W-1:0]  whole_steps;
   logic [BYTE_W-1:0]  read_byte;
   ebr_event_type      ev;

   assign produces  = !err_ff && (cmd_ff == CMD_READ);
   // Only a read needs room in the result register.
   assign advance   = in_valid_ff && (!produces || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      ev            = '0;
      ev.ab         = ab_ff;
      ev.button     = btn_ff;
      ev.error_bits = ebits_ff;
      if (advance) begin
         if (err_ff) begin
            ev.error = 1'b1;
         end else begin
            case (cmd_ff)
               CMD_TICK:   ev.tick   = 1'b1;
               CMD_SAMPLE: ev.sample = 1'b1;
               CMD_PRESS:  ev.press  = 1'b1;
               CMD_HOLD:   ev.hold   = 1'b1;
               CMD_MATCH:  ev.match  = 1'b1;
               CMD_READ:   ev.read   = 1'b1;
               default:    ev        = ev;
            endcase
         end
      end
   end

   ebr_encoder u_encoder (
      .clock            (clock),
      .reset            (reset),
      .ev               (ev),
      .snap_take        (snap_take),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .whole_steps      (whole_steps)
   );

   ebr_report #(
      .BUTTONS (BUTTONS)
   ) u_report (
      .clock       (clock),
      .reset       (reset),
      .ev          (ev),
      .whole_steps (whole_steps),
      .snap_take   (snap_take),
      .read_byte   (read_byte)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (ev.read) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff   <= req_command;
         ab_ff    <= req_encoder_ab;
         btn_ff   <= req_button_index;
         err_ff   <= req_bus_error;
         ebits_ff <= req_error_bits;
      end
      if (ev.read) begin
         rsp_data_ff <= read_byte;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = rsp_data_ff;
   assign rsp_read_valid = 1'b1;

endmodule

// ===== design/ebr_checker.sv =====
// Port-level checks for the encoder/button report block, bound to the top
// level. Depends on ebr_pkg and encoder_button_i2c_report.
module ebr_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [ebr_pkg::BYTE_W-1:0] rsp_read_data,
   input logic                       rsp_read_valid
);
   import ebr_pkg::*;

   // Back-pressure only reaches the input when a result is held.
   a_ready_low_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("req_ready low without a stalled result");

   a_result_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_read_valid)
      else $error("result without read_valid");

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

   a_held_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_read_data)))
      else $error("stalled result changed");

endmodule

bind encoder_button_i2c_report ebr_checker u_ebr_checker (.*);

// ===== dv/encoder_button_i2c_report_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for encoder_button_i2c_report: drives panel events, predicts
// every report byte and compares each byte read back. Needs ebr_pkg and the block's RTL.
module encoder_button_i2c_report_test;
   import ebr_pkg::*;

   localparam int BUTTONS     = BUTTONS_DEF;
   localparam int CYCLE_LIMIT = 200000;
   // Ample margin for an accepted item to reach the result register.
   localparam int SETTLE      = 6;
   // Commands the block leaves unused.
   localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [AB_W-1:0]   ab;
      logic [BTN_W-1:0]  button;
      logic              bus_err;
      logic [BYTE_W-1:0] err_bits;
   } panel_event_t;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              valid;
   } read_byte_t;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   panel_event_t          req_item;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [BYTE_W-1:0]     rsp_read_data;
   logic                  rsp_read_valid;
   logic                  csr_write_enable;
   logic [DEBOUNCE_W-1:0] csr_write_data;

   // Traffic shaping, set by the tests between phases
   int idle_pct;
   int stall_pct;
   int holdoff_left;

   // Run statistics
   int cycle_count;
   int fail_count;
   int items_sent;
   int reads_checked;
   int settings_used;

   // Phase of the encoder as last driven, so walks carry on from it
   logic [AB_W-1:0] walk_phase;

   // Predicted state of the panel
   logic [AB_W-1:0]       enc_phase;
   logic signed [7:0]     enc_steps;
   logic [IDLE_W-1:0]     idle_count;
   logic [BYTE_W-1:0]     press_cnt [BUTTONS];
   logic [BYTE_W-1:0]     hold_cnt [BUTTONS];
   logic [BYTE_W-1:0]     status_byte;
   logic [BYTE_W-1:0]     report [REPORT_BYTES];
   int unsigned           report_pos;
   logic [DEBOUNCE_W-1:0] debounce_limit;

   read_byte_t expected_reads[$];

   encoder_button_i2c_report u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_item.command),
      .req_encoder_ab   (req_item.ab),
      .req_button_index (req_item.button),
      .req_bus_error    (req_item.bus_err),
      .req_error_bits   (req_item.err_bits),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_data    (rsp_read_data),
      .rsp_read_valid   (rsp_read_valid),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------------
   // Panel prediction
   // ---------------------------------------------------------------------------------------

   function automatic logic signed [7:0] clamp_steps(input int v);
      if (v > 127)
         return 8'sd127;
      if (v < -128)
         return -8'sd128;
      return v[7:0];
   endfunction

   // Position along the quadrature cycle: 00, 01, 11, 10 map to 0..3.
   function automatic logic [1:0] step_phase(input logic [1:0] ph, input logic up);
      logic [1:0] pos;
      pos = {ph[1], ^ph};
      pos = up ? pos + 2'd1 : pos - 2'd1;
      return {pos[1], pos[1] ^ pos[0]};
   endfunction

   function automatic void reset_panel();
      enc_phase      = '0;
      enc_steps      = '0;
      idle_count     = '0;
      status_byte    = '0;
      report_pos     = 0;
      debounce_limit = DEBOUNCE_RESET;
      for (int i = 0; i < BUTTONS; i++) begin
         press_cnt[i] = '0;
         hold_cnt[i]  = '0;
      end
      for (int i = 0; i < REPORT_BYTES; i++)
         report[i] = '0;
   endfunction

   function automatic void apply_event(input panel_event_t ev);
      int               s;
      int               whole;
      logic [1:0]       d;
      logic [BYTE_W-1:0] data;
      // A bus error overrides whatever command rides along
      if (ev.bus_err) begin
         status_byte |= ev.err_bits;
         report_pos  = 0;
         return;
      end
      case (ev.command)
         CMD_TICK:
            if (idle_count != IDLE_MAX)
               idle_count++;
         CMD_SAMPLE: begin
            s = enc_steps;
            // stale partial step dropped after a long quiet spell
            if (idle_count > debounce_limit && s > -4 && s < 4)
               s = 0;
            d = {ev.ab[1], ^ev.ab} - {enc_phase[1], ^enc_phase};
            if (d == 2'd1)
               s = s + 1;
            else if (d == 2'd3)
               s = s - 1;
            enc_steps  = clamp_steps(s);
            enc_phase  = ev.ab;
            idle_count = '0;
         end
         CMD_PRESS:
            if (ev.button < BUTTONS)
               press_cnt[ev.button]++;
         CMD_HOLD:
            if (ev.button < BUTTONS)
               hold_cnt[ev.button]++;
         CMD_MATCH:
            report_pos = 0;
         CMD_READ: begin
            if (report_pos == 0) begin
               // first byte of a transfer freezes the report and clears the counters
               s     = enc_steps;
               whole = s / 4;
               for (int i = 0; i < REPORT_BYTES; i++)
                  report[i] = '0;
               report[0] = status_byte;
               report[1] = whole[7:0];
               enc_steps = clamp_steps(s % 4);
               for (int i = 0; i < BUTTONS; i++) begin
                  if (2 + i < REPORT_BYTES)
                     report[2 + i] = press_cnt[i];
                  if (2 + BUTTONS + i < REPORT_BYTES)
                     report[2 + BUTTONS + i] = hold_cnt[i];
                  press_cnt[i] = '0;
                  hold_cnt[i]  = '0;
               end
            end
            if (report_pos < REPORT_BYTES) begin
               data = report[report_pos];
               report_pos++;
            end else
               data = PAST_END_BYTE;
            expected_reads.push_back(read_byte_t'{data: data, valid: 1'b1});
         end
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------------------------------
   // Monitor: everything is sampled at the rising edge. Accepted items feed the
   // prediction, returned bytes are checked against the oldest expectation.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      read_byte_t exp_byte;
      if (!reset) begin
         if (csr_write_enable)
            debounce_limit = csr_write_data;
         if (req_valid && req_ready)
            apply_event(req_item);
         if (rsp_valid && rsp_ready) begin
            if (expected_reads.size() == 0) begin
               $display("%0t: read byte %02h returned with nothing expected",
                        $time, rsp_read_data);
               fail_count++;
            end else begin
               exp_byte = expected_reads.pop_front();
               reads_checked++;
               if (rsp_read_data !== exp_byte.data) begin
                  $display("%0t: read_data mismatch, expected %02h, got %02h",
                           $time, exp_byte.data, rsp_read_data);
                  fail_count++;
               end
               if (rsp_read_valid !== exp_byte.valid) begin
                  $display("%0t: read_valid mismatch, expected %0b, got %0b",
                           $time, exp_byte.valid, rsp_read_valid);
                  fail_count++;
               end
            end
         end
      end
   end

   // Receiver: a long hold-off takes priority over the random stall rate.
   always @(negedge clock) begin
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_ready <= 1'b0;
      end else
         rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run stopped after %0d cycles", $time, cycle_count);
         $display("encoder_button_i2c_report_test NOT OK");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Driving
   // ---------------------------------------------------------------------------------------

   // Offers one item and returns just after the edge that accepted it. Valid stays
   // high on return, so back-to-back items keep it asserted.
   task automatic send_event(input logic [CMD_W-1:0]  cmd,
                             input logic [AB_W-1:0]   ab   = '0,
                             input logic [BTN_W-1:0]  btn  = '0,
                             input logic              err  = 1'b0,
                             input logic [BYTE_W-1:0] bits = '0);
      panel_event_t ev;
      ev = '{command: cmd, ab: ab, button: btn, bus_err: err, err_bits: bits};
      if (cmd == CMD_SAMPLE && !err)
         walk_phase = ab;
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_item  <= ev;
      req_valid <= 1'b1;
      do
         @(posedge clock);
      while (!req_ready);
      items_sent++;
   endtask

   // Stops offering and waits for every predicted byte, then lets the pipe empty.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_reads.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_debounce(input logic [DEBOUNCE_W-1:0] ms);
      drain();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= ms;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   // ---------------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------------

   // Gray steps, double jump, repeat, buttons in and out of range, spare commands,
   // a short transfer, and bus errors carried on other commands.
   task automatic test_directed();
      send_event(CMD_SAMPLE, 2'b01);
      send_event(CMD_SAMPLE, 2'b11);
      send_event(CMD_SAMPLE, 2'b00);      // jump of two phases
      send_event(CMD_SAMPLE, 2'b00);      // no change
      send_event(CMD_SAMPLE, 2'b10);      // backward
      send_event(CMD_PRESS, 2'b00, 3'd0);
      send_event(CMD_PRESS, 2'b00, 3'd4);
      send_event(CMD_PRESS, 2'b00, 3'd7); // out of range, ignored
      send_event(CMD_HOLD, 2'b00, 3'd2);
      send_event(CMD_HOLD, 2'b00, 3'd5);  // out of range, ignored
      send_event(CMD_SPARE_6, 2'b11, 3'd7);
      send_event(CMD_SPARE_7);
      send_event(CMD_MATCH);
      repeat (4) send_event(CMD_READ);
      send_event(CMD_READ, 2'b11, 3'd7, 1'b1, 8'hA5);
      send_event(CMD_READ);                // fresh report after the error
      send_event(CMD_TICK, 2'b11, 3'd7, 1'b1, 8'h5A);
      send_event(CMD_MATCH);
      repeat (2) send_event(CMD_READ);
      drain();
   endtask

   // Whole report, reads beyond it, then a bus error restarting the index.
   task automatic test_read_past_end();
      send_event(CMD_PRESS, 2'b00, 3'd3);
      send_event(CMD_MATCH);
      repeat (15) send_event(CMD_READ);
      send_event(CMD_MATCH, 2'b00, 3'd0, 1'b1, 8'h00);
      send_event(CMD_READ);
      drain();
   endtask

   // Press and hold counters wrapping past 255; the last hold byte sits at the end.
   task automatic test_counter_wrap();
      repeat (257) send_event(CMD_PRESS, 2'b00, 3'd1);
      repeat (258) send_event(CMD_HOLD, 2'b00, 3'd4);
      repeat (3) send_event(CMD_PRESS, 2'b00, 3'd3);
      send_event(CMD_MATCH);
      repeat (REPORT_BYTES) send_event(CMD_READ);
      drain();
   endtask

   // Step count pinned at both ends of its range.
   task automatic test_step_saturation();
      repeat (140) send_event(CMD_SAMPLE, step_phase(walk_phase, 1'b1));
      send_event(CMD_MATCH);
      repeat (2) send_event(CMD_READ);
      repeat (300) send_event(CMD_SAMPLE, step_phase(walk_phase, 1'b0));
      send_event(CMD_MATCH);
      repeat (2) send_event(CMD_READ);
      drain();
   endtask

   // With the longest debounce, the idle counter must stick at its top rather than
   // wrap, or the partial count would survive and show up as a whole step.
   task automatic test_tick_saturation();
      set_debounce(10'd1023);
      repeat (2) send_event(CMD_SAMPLE, step_phase(walk_phase, 1'b1));
      repeat (2100) send_event(CMD_TICK);
      repeat (2) send_event(CMD_SAMPLE, step_phase(walk_phase, 1'b1));
      send_event(CMD_MATCH);
      repeat (2) send_event(CMD_READ);
      drain();
   endtask

   // Receiver held off long enough for reads to back up into the input side,
   // then a pause until every byte is home before carrying on.
   task automatic test_backpressure();
      idle_pct     = 0;
      stall_pct    = 0;
      holdoff_left = 150;
      send_event(CMD_MATCH);
      repeat (20) begin
         send_event(CMD_READ);
         send_event(CMD_TICK);
      end
      drain();
      send_event(CMD_MATCH);
      repeat (6) send_event(CMD_READ);
      drain();
   endtask

   // Mostly well-formed traffic: Gray walks, tick bursts, button events and
   // transfers, with bus errors and raw noise mixed in.
   task automatic run_random(input int target);
      int         done;
      int         pick;
      int         n;
      logic       dir;
      logic [2:0] btn;
      logic [2:0] cmd;
      logic       err;
      done = 0;
      while (done < target) begin
         pick = $urandom_range(99);
         if (pick < 25) begin
            dir = 1'($urandom_range(1));
            n   = $urandom_range(1, 10);
            repeat (n) begin
               if ($urandom_range(5) == 0)
                  send_event(CMD_SAMPLE, AB_W'($urandom_range(3)));
               else
                  send_event(CMD_SAMPLE, step_phase(walk_phase, dir));
               done++;
            end
         end else if (pick < 40) begin
            n = $urandom_range(1, 40);
            repeat (n) send_event(CMD_TICK);
            done += n;
         end else if (pick < 58) begin
            btn = BTN_W'(($urandom_range(7) == 0) ? $urandom_range(7)
                                                   : $urandom_range(BUTTONS - 1));
            if ($urandom_range(1))
               send_event(CMD_PRESS, AB_W'($urandom_range(3)), btn);
            else
               send_event(CMD_HOLD, AB_W'($urandom_range(3)), btn);
            if (btn < BUTTONS)
               done++;
         end else if (pick < 88) begin
            if ($urandom_range(6) != 0) begin
               send_event(CMD_MATCH);
               done++;
            end
            n = $urandom_range(1, 14);
            repeat (n) begin
               // occasional error in the middle of a transfer
               if ($urandom_range(11) == 0)
                  send_event(CMD_W'($urandom_range(7)), AB_W'($urandom_range(3)),
                             BTN_W'($urandom_range(7)), 1'b1,
                             8'h01 << $urandom_range(7));
               else
                  send_event(CMD_READ, AB_W'($urandom_range(3)),
                             BTN_W'($urandom_range(7)));
               done++;
            end
         end else if (pick < 94) begin
            send_event(CMD_W'($urandom_range(7)), AB_W'($urandom_range(3)),
                       BTN_W'($urandom_range(7)), 1'b1, BYTE_W'($urandom_range(255)));
            done++;
         end else begin
            cmd = CMD_W'($urandom_range(7));
            btn = BTN_W'($urandom_range(7));
            err = ($urandom_range(5) == 0);
            send_event(cmd, AB_W'($urandom_range(3)), btn, err,
                       BYTE_W'($urandom_range(255)));
            if (err || !(cmd == CMD_SPARE_6 || cmd == CMD_SPARE_7 ||
                         ((cmd == CMD_PRESS || cmd == CMD_HOLD) && btn >= BUTTONS)))
               done++;
         end
      end
   endtask

   // Four traffic mixes, each with its own debounce setting.
   task automatic test_random_phases();
      int idle_mode [4];
      int stall_mode [4];
      idle_mode  = '{0, 48, 0, 6};
      stall_mode = '{0, 0, 48, 6};
      for (int p = 0; p < 4; p++) begin
         case (p)
            0:       set_debounce(10'd0);
            1:       set_debounce(DEBOUNCE_W'($urandom_range(1, 25)));
            2:       set_debounce(DEBOUNCE_W'($urandom_range(0, 40)));
            default: set_debounce(DEBOUNCE_W'($urandom_range(2, 12)));
         endcase
         idle_pct  = idle_mode[p];
         stall_pct = stall_mode[p];
         run_random(215);
         drain();
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------------------
   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_item         = '0;
      rsp_ready        = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      idle_pct         = 0;
      stall_pct        = 0;
      holdoff_left     = 0;
      cycle_count      = 0;
      fail_count       = 0;
      items_sent       = 0;
      reads_checked    = 0;
      settings_used    = 0;
      walk_phase       = '0;
      reset_panel();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_read_past_end();
      idle_pct  = 6;
      stall_pct = 6;
      test_counter_wrap();
      test_step_saturation();
      idle_pct  = 0;
      stall_pct = 0;
      test_tick_saturation();
      test_backpressure();
      test_random_phases();
      drain();

      $display("Covered %0d items and %0d read bytes over %0d debounce writes,",
               items_sent, reads_checked, settings_used);
      $display("with stall, hold-off and saturation cases; %0d mismatches.", fail_count);
      if (fail_count == 0)
         $display("encoder_button_i2c_report_test OK");
      else
         $display("encoder_button_i2c_report_test NOT OK");
      $finish;
   end

endmodule
